// ===== src/bsmm_pkg.sv =====
// Shared types and constants of the bounded min/max stack.
// No dependencies; every other file but bsmm_ram imports this package.
package bsmm_pkg;

  localparam int CFG_W          = 7;
  localparam int DATA_W         = 32;
  localparam int OCC_W          = 7;
  localparam int DEFAULT_DEPTH  = 64;
  localparam int DEFAULT_WORD_W = 32;

  localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(6);

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } action_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic                     popped_valid;
    logic                     overflow;
    logic                     underflow;
    logic [OCC_W-1:0]         occupancy;
    logic                     is_empty;
    logic signed [DATA_W-1:0] min_value;
    logic signed [DATA_W-1:0] max_value;
  } result_t;

endpackage

// ===== src/bsmm_if.sv =====
// Request and response channel interfaces of the bounded min/max stack.
// Depends on bsmm_pkg.
interface bsmm_req_if import bsmm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     action;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, output action, output push_value, input ready);
  modport sink   (input valid, input action, input push_value, output ready);
endinterface

interface bsmm_rsp_if import bsmm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] popped_value;
  logic                     popped_valid;
  logic                     overflow;
  logic                     underflow;
  logic [OCC_W-1:0]         occupancy;
  logic                     is_empty;
  logic signed [DATA_W-1:0] min_value;
  logic signed [DATA_W-1:0] max_value;

  modport source (output valid, output popped_value, output popped_valid, output overflow,
                  output underflow, output occupancy, output is_empty, output min_value,
                  output max_value, input ready);
  modport sink   (input valid, input popped_value, input popped_valid, input overflow,
                  input underflow, input occupancy, input is_empty, input min_value,
                  input max_value, output ready);
endinterface

// ===== src/bounded_stack_min_max.sv =====
// Bounded LIFO stack of signed words that reports occupancy and the minimum and maximum
// of the words held with every result. A push, a refused push (overflow) and a pop from
// an empty stack (underflow) each register their result from ST_IDLE; a successful pop
// passes through ST_POP while the word and min/max memories return registered read data.
// Each level's running min and max are stored beside it, so no scan is ever needed.
// No clearing pass follows reset. capacity_limit resets to 6 and is clamped to STACK_DEPTH;
// write it while idle. Depends on bsmm_pkg, the channel interfaces, bsmm_ram and bsmm_ctrl.
module bounded_stack_min_max import bsmm_pkg::*; #(
  parameter int STACK_DEPTH = DEFAULT_DEPTH,
  parameter int WORD_WIDTH  = DEFAULT_WORD_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  bsmm_req_if.sink         req,
  bsmm_rsp_if.source       rsp
);

  localparam int ADDR_W = $clog2(STACK_DEPTH);

  logic [CFG_W-1:0]        capacity_limit;
  logic                    word_we;
  logic                    mm_we;
  logic [ADDR_W-1:0]       word_waddr;
  logic [WORD_WIDTH-1:0]   word_wdata;
  logic [2*WORD_WIDTH-1:0] mm_wdata;
  logic                    rd_en;
  logic [ADDR_W-1:0]       word_raddr;
  logic [ADDR_W-1:0]       mm_raddr;
  logic [WORD_WIDTH-1:0]   word_rdata;
  logic [2*WORD_WIDTH-1:0] mm_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= CAP_RESET;
    end else if (cfg_we) begin
      capacity_limit <= cfg_wdata;
    end
  end

  bsmm_ctrl #(
    .STACK_DEPTH (STACK_DEPTH),
    .WORD_WIDTH  (WORD_WIDTH)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .capacity_limit (capacity_limit),
    .req            (req),
    .rsp            (rsp),
    .word_we        (word_we),
    .mm_we          (mm_we),
    .word_waddr     (word_waddr),
    .word_wdata     (word_wdata),
    .mm_wdata       (mm_wdata),
    .rd_en          (rd_en),
    .word_raddr     (word_raddr),
    .mm_raddr       (mm_raddr),
    .word_rdata     (word_rdata),
    .mm_rdata       (mm_rdata)
  );

  bsmm_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_word_ram (
    .clk   (clk),
    .we    (word_we),
    .waddr (word_waddr),
    .wdata (word_wdata),
    .re    (rd_en),
    .raddr (word_raddr),
    .rdata (word_rdata)
  );

  bsmm_ram #(
    .WIDTH (2 * WORD_WIDTH),
    .DEPTH (STACK_DEPTH)
  ) u_mm_ram (
    .clk   (clk),
    .we    (mm_we),
    .waddr (word_waddr),
    .wdata (mm_wdata),
    .re    (rd_en),
    .raddr (mm_raddr),
    .rdata (mm_rdata)
  );

endmodule

// ===== src/bsmm_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bsmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/bsmm_ctrl.sv =====
// Stack sequencer: pointer, top-of-stack min/max, memory accesses and result register.
// Depends on bsmm_pkg and the channel interfaces; drives the word and min/max RAMs.
module bsmm_ctrl import bsmm_pkg::*; #(
  parameter int STACK_DEPTH = DEFAULT_DEPTH,
  parameter int WORD_WIDTH  = DEFAULT_WORD_W
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [CFG_W-1:0]               capacity_limit,
  bsmm_req_if.sink                       req,
  bsmm_rsp_if.source                     rsp,
  output logic                           word_we,
  output logic                           mm_we,
  output logic [$clog2(STACK_DEPTH)-1:0] word_waddr,
  output logic [WORD_WIDTH-1:0]          word_wdata,
  output logic [2*WORD_WIDTH-1:0]        mm_wdata,
  output logic                           rd_en,
  output logic [$clog2(STACK_DEPTH)-1:0] word_raddr,
  output logic [$clog2(STACK_DEPTH)-1:0] mm_raddr,
  input  logic [WORD_WIDTH-1:0]          word_rdata,
  input  logic [2*WORD_WIDTH-1:0]        mm_rdata
);

  localparam int PTR_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int CMP_W  = (PTR_W > CFG_W) ? PTR_W : CFG_W;

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_t;

  state_t                       state;
  logic [PTR_W-1:0]             sp;
  logic signed [WORD_WIDTH-1:0] cur_min;
  logic signed [WORD_WIDTH-1:0] cur_max;
  result_t                      res;
  logic                         res_valid;

  logic                         take;
  logic                         is_push;
  logic                         full;
  logic                         empty;
  logic signed [WORD_WIDTH-1:0] v;
  logic signed [WORD_WIDTH-1:0] lo;
  logic signed [WORD_WIDTH-1:0] hi;
  logic signed [WORD_WIDTH-1:0] rd_word;
  logic signed [WORD_WIDTH-1:0] rd_min;
  logic signed [WORD_WIDTH-1:0] rd_max;
  logic [PTR_W-1:0]             sp_inc;
  logic [PTR_W-1:0]             sp_dec;

  assign req.ready = (state == ST_IDLE) && (!res_valid || rsp.ready);
  assign take      = req.valid && req.ready;
  assign is_push   = (action_t'(req.action) == ACT_PUSH);
  assign empty     = (sp == '0);
  assign full      = (CMP_W'(sp) >= CMP_W'(capacity_limit)) ||
                     (CMP_W'(sp) == CMP_W'(STACK_DEPTH));
  assign sp_inc    = sp + PTR_W'(1);
  assign sp_dec    = sp - PTR_W'(1);

  assign v  = WORD_WIDTH'(req.push_value);
  assign lo = (!empty && (cur_min < v)) ? cur_min : v;
  assign hi = (!empty && (cur_max > v)) ? cur_max : v;

  assign word_we    = take && is_push && !full;
  assign mm_we      = word_we;
  assign word_waddr = ADDR_W'(sp);
  assign word_wdata = v;
  assign mm_wdata   = {hi, lo};

  assign rd_en      = take && !is_push && !empty;
  assign word_raddr = ADDR_W'(sp_dec);
  assign mm_raddr   = ADDR_W'(sp - PTR_W'(2));

  assign rd_word = word_rdata;
  assign rd_min  = mm_rdata[WORD_WIDTH-1:0];
  assign rd_max  = mm_rdata[2*WORD_WIDTH-1:WORD_WIDTH];

  assign rsp.valid        = res_valid;
  assign rsp.popped_value = res.popped_value;
  assign rsp.popped_valid = res.popped_valid;
  assign rsp.overflow     = res.overflow;
  assign rsp.underflow    = res.underflow;
  assign rsp.occupancy    = res.occupancy;
  assign rsp.is_empty     = res.is_empty;
  assign rsp.min_value    = res.min_value;
  assign rsp.max_value    = res.max_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      sp        <= '0;
      cur_min   <= '0;
      cur_max   <= '0;
      res_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (take) begin
            if (is_push && !full) begin
              res_valid        <= 1'b1;
              sp               <= sp_inc;
              cur_min          <= lo;
              cur_max          <= hi;
              res.popped_value <= '0;
              res.popped_valid <= 1'b0;
              res.overflow     <= 1'b0;
              res.underflow    <= 1'b0;
              res.occupancy    <= OCC_W'(sp_inc);
              res.is_empty     <= 1'b0;
              res.min_value    <= DATA_W'(lo);
              res.max_value    <= DATA_W'(hi);
            end else if (is_push || empty) begin
              res_valid        <= 1'b1;
              res.popped_value <= '0;
              res.popped_valid <= 1'b0;
              res.overflow     <= is_push;
              res.underflow    <= !is_push;
              res.occupancy    <= OCC_W'(sp);
              res.is_empty     <= empty;
              res.min_value    <= DATA_W'(cur_min);
              res.max_value    <= DATA_W'(cur_max);
            end else begin
              res_valid <= 1'b0;
              sp        <= sp_dec;
              state     <= ST_POP;
            end
          end else if (rsp.ready) begin
            res_valid <= 1'b0;
          end
        end
        ST_POP: begin
          res_valid        <= 1'b1;
          res.popped_value <= DATA_W'(rd_word);
          res.popped_valid <= 1'b1;
          res.overflow     <= 1'b0;
          res.underflow    <= 1'b0;
          res.occupancy    <= OCC_W'(sp);
          res.is_empty     <= empty;
          if (empty) begin
            cur_min       <= '0;
            cur_max       <= '0;
            res.min_value <= '0;
            res.max_value <= '0;
          end else begin
            cur_min       <= rd_min;
            cur_max       <= rd_max;
            res.min_value <= DATA_W'(rd_min);
            res.max_value <= DATA_W'(rd_max);
          end
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== tb/sv/bounded_stack_min_max_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for bounded_stack_min_max: a directed table, then random push/pop
// phases under several capacity limits, each result checked against its table row or the stack model.
// Depends on bsmm_pkg, the channel interfaces in bsmm_if and the stack RTL.
module bounded_stack_min_max_tb import bsmm_pkg::*; ();

  typedef struct {
    action_t                  act;
    logic signed [DATA_W-1:0] val;
    bit                       typed;
    result_t                  res;
  } stim_row_t;

  typedef struct {
    int cap;
    int push_pct;
    int len;
    bit steady;
  } phase_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  bsmm_req_if req_ch ();
  bsmm_rsp_if rsp_ch ();

  bounded_stack_min_max u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stack model state
  logic signed [DATA_W-1:0] stack_words [DEFAULT_DEPTH];
  logic signed [DATA_W-1:0] level_min   [DEFAULT_DEPTH];
  logic signed [DATA_W-1:0] level_max   [DEFAULT_DEPTH];
  int                       held = 0;
  logic [CFG_W-1:0]         cap_limit = CAP_RESET;

  result_t   pending_results [$];
  int        errors = 0;
  bit        steady = 1'b0;
  bit        row_typed = 1'b0;
  result_t   row_res = '0;
  stim_row_t dir_rows [$];
  phase_t    phases [$];

  function automatic result_t apply_stack_op(action_t act, logic signed [DATA_W-1:0] val);
    result_t r;
    int      lim;
    r = '0;
    lim = (cap_limit > DEFAULT_DEPTH) ? DEFAULT_DEPTH : int'(cap_limit);
    if (act == ACT_PUSH) begin
      if (held >= lim) begin
        r.overflow = 1'b1;
      end else begin
        stack_words[held] = val;
        level_min[held] = (held > 0 && level_min[held-1] < val) ? level_min[held-1] : val;
        level_max[held] = (held > 0 && level_max[held-1] > val) ? level_max[held-1] : val;
        held++;
      end
    end else if (held == 0) begin
      r.underflow = 1'b1;
    end else begin
      held--;
      r.popped_value = stack_words[held];
      r.popped_valid = 1'b1;
    end
    r.occupancy = OCC_W'(held);
    r.is_empty  = (held == 0);
    if (held > 0) begin
      r.min_value = level_min[held-1];
      r.max_value = level_max[held-1];
    end
    return r;
  endfunction

  function automatic result_t mk_res(logic [31:0] pval, int pv, int ovf, int udf, int occ,
                                     int emp, logic [31:0] mn, logic [31:0] mx);
    result_t r;
    r.popped_value = pval;
    r.popped_valid = 1'(pv);
    r.overflow     = 1'(ovf);
    r.underflow    = 1'(udf);
    r.occupancy    = OCC_W'(occ);
    r.is_empty     = 1'(emp);
    r.min_value    = mn;
    r.max_value    = mx;
    return r;
  endfunction

  function automatic void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t ns: %s mismatch, expected %h, got %h", $realtime, name, exp_v, act_v);
      errors++;
    end
  endfunction

  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFFFFFF;
      1:       return 32'sh80000000;
      2, 3, 4: return DATA_W'($signed($urandom_range(0, 20)) - 10);
      default: return $urandom;
    endcase
  endfunction

  // Record each accepted request, then retire each accepted result
  always @(posedge clk) begin
    result_t e;
    if (!rst && req_ch.valid && req_ch.ready) begin
      e = apply_stack_op(action_t'(req_ch.action), req_ch.push_value);
      pending_results.push_back(row_typed ? row_res : e);
    end
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result transfer, nothing pending", $realtime);
        errors++;
      end else begin
        e = pending_results.pop_front();
        compare_field("popped_value", e.popped_value, rsp_ch.popped_value);
        compare_field("popped_valid", 32'(e.popped_valid), 32'(rsp_ch.popped_valid));
        compare_field("overflow", 32'(e.overflow), 32'(rsp_ch.overflow));
        compare_field("underflow", 32'(e.underflow), 32'(rsp_ch.underflow));
        compare_field("occupancy", 32'(e.occupancy), 32'(rsp_ch.occupancy));
        compare_field("is_empty", 32'(e.is_empty), 32'(rsp_ch.is_empty));
        compare_field("min_value", e.min_value, rsp_ch.min_value);
        compare_field("max_value", e.max_value, rsp_ch.max_value);
      end
    end
  end

  initial begin
    int stall_left;
    stall_left = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0 && !steady) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
        stall_left = 0;
        if (!steady && $urandom_range(0, 3) == 0) stall_left = pause_len();
      end
    end
  end

  task automatic send_item(action_t act, logic signed [DATA_W-1:0] val, bit typed, result_t res);
    int gap;
    req_ch.valid      <= 1'b1;
    req_ch.action     <= act;
    req_ch.push_value <= val;
    row_typed         <= typed;
    row_res           <= res;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
    gap = (!steady && $urandom_range(0, 2) == 0) ? pause_len() : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_limit(logic [CFG_W-1:0] v);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    cap_limit = v;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int      cap;
    action_t act;
    req_ch.valid      = 1'b0;
    req_ch.action     = ACT_PUSH;
    req_ch.push_value = '0;

    dir_rows.push_back('{ACT_POP, 0, 1'b1, mk_res(0, 0, 0, 1, 0, 1, 0, 0)});
    dir_rows.push_back('{ACT_PUSH, 32'sh7FFFFFFF, 1'b1,
                         mk_res(0, 0, 0, 0, 1, 0, 32'h7FFFFFFF, 32'h7FFFFFFF)});
    dir_rows.push_back('{ACT_PUSH, 32'sh80000000, 1'b1,
                         mk_res(0, 0, 0, 0, 2, 0, 32'h80000000, 32'h7FFFFFFF)});
    dir_rows.push_back('{ACT_PUSH, 0, 1'b1,
                         mk_res(0, 0, 0, 0, 3, 0, 32'h80000000, 32'h7FFFFFFF)});
    dir_rows.push_back('{ACT_PUSH, -1, 1'b1,
                         mk_res(0, 0, 0, 0, 4, 0, 32'h80000000, 32'h7FFFFFFF)});
    dir_rows.push_back('{ACT_PUSH, 32'shAAAAAAAA, 1'b1,
                         mk_res(0, 0, 0, 0, 5, 0, 32'h80000000, 32'h7FFFFFFF)});
    dir_rows.push_back('{ACT_PUSH, 32'sh55555555, 1'b1,
                         mk_res(0, 0, 0, 0, 6, 0, 32'h80000000, 32'h7FFFFFFF)});
    dir_rows.push_back('{ACT_PUSH, 32'sh12345678, 1'b1,
                         mk_res(0, 0, 1, 0, 6, 0, 32'h80000000, 32'h7FFFFFFF)});
    dir_rows.push_back('{ACT_POP, 0, 1'b1,
                         mk_res(32'h55555555, 1, 0, 0, 5, 0, 32'h80000000, 32'h7FFFFFFF)});
    dir_rows.push_back('{ACT_POP, 0, 1'b1,
                         mk_res(32'hAAAAAAAA, 1, 0, 0, 4, 0, 32'h80000000, 32'h7FFFFFFF)});
    dir_rows.push_back('{ACT_POP, 0, 1'b1,
                         mk_res(32'hFFFFFFFF, 1, 0, 0, 3, 0, 32'h80000000, 32'h7FFFFFFF)});
    dir_rows.push_back('{ACT_POP, 0, 1'b1,
                         mk_res(0, 1, 0, 0, 2, 0, 32'h80000000, 32'h7FFFFFFF)});
    dir_rows.push_back('{ACT_POP, 0, 1'b1,
                         mk_res(32'h80000000, 1, 0, 0, 1, 0, 32'h7FFFFFFF, 32'h7FFFFFFF)});
    dir_rows.push_back('{ACT_POP, 0, 1'b1, mk_res(32'h7FFFFFFF, 1, 0, 0, 0, 1, 0, 0)});
    dir_rows.push_back('{ACT_POP, 0, 1'b1, mk_res(0, 0, 0, 1, 0, 1, 0, 0)});
    dir_rows.push_back('{ACT_PUSH, 3, 1'b0, '0});
    dir_rows.push_back('{ACT_PUSH, -5, 1'b0, '0});
    dir_rows.push_back('{ACT_PUSH, 10, 1'b0, '0});
    dir_rows.push_back('{ACT_PUSH, -5, 1'b0, '0});
    dir_rows.push_back('{ACT_POP, 32'sh7FFFFFFF, 1'b0, '0});
    dir_rows.push_back('{ACT_POP, 0, 1'b0, '0});
    dir_rows.push_back('{ACT_PUSH, 2, 1'b0, '0});
    dir_rows.push_back('{ACT_POP, 0, 1'b0, '0});
    dir_rows.push_back('{ACT_POP, 0, 1'b0, '0});
    dir_rows.push_back('{ACT_POP, 0, 1'b0, '0});
    dir_rows.push_back('{ACT_POP, 0, 1'b0, '0});

    // Limit of -1 picks a random setting
    phases.push_back('{64, 80, 200, 1'b0});
    phases.push_back('{3, 50, 120, 1'b0});
    phases.push_back('{0, 50, 60, 1'b0});
    phases.push_back('{1, 50, 100, 1'b0});
    phases.push_back('{127, 75, 200, 1'b0});
    phases.push_back('{127, 30, 150, 1'b0});
    phases.push_back('{64, 55, 150, 1'b1});
    phases.push_back('{6, 50, 80, 1'b0});
    phases.push_back('{-1, 60, 70, 1'b0});
    phases.push_back('{-1, 50, 70, 1'b0});
    phases.push_back('{-1, 65, 70, 1'b0});
    phases.push_back('{-1, 40, 70, 1'b0});

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) send_item(dir_rows[i].act, dir_rows[i].val, dir_rows[i].typed,
                                    dir_rows[i].res);

    foreach (phases[p]) begin
      cap = (phases[p].cap < 0) ? $urandom_range(0, 127) : phases[p].cap;
      write_limit(CFG_W'(cap));
      steady = phases[p].steady;
      repeat (phases[p].len) begin
        if ($urandom_range(0, 99) == 0 && pending_results.size() != 0) begin
          req_ch.valid <= 1'b0;
          while (pending_results.size() != 0) @(negedge clk);
        end
        act = ($urandom_range(0, 99) < phases[p].push_pct) ? ACT_PUSH : ACT_POP;
        send_item(act, pick_word(), 1'b0, '0);
      end
      steady = 1'b0;
    end

    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
